// File: rtl/sbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_pkg: shared types and constants
// Item structs, action and mirroring codes, register indexes and the
// mapping view that the state block hands to the translation logic.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Action codes of an input item
  typedef enum logic [1:0] {
    ACT_PRG_READ  = 2'd0,
    ACT_MAP_WRITE = 2'd1,
    ACT_PATTERN   = 2'd2,
    ACT_NAMETABLE = 2'd3
  } action_e;

  // Mirroring modes
  typedef enum logic [1:0] {
    MIR_SINGLE_LO  = 2'd0,
    MIR_SINGLE_HI  = 2'd1,
    MIR_VERTICAL   = 2'd2,
    MIR_HORIZONTAL = 2'd3
  } mirror_e;

  // Target of a completed serial load (address bits 14..13)
  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PROGRAM  = 2'd3
  } load_target_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_BANK_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CHR_BANK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_HEADER_VMIRROR  = 2'd2;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 6;
  localparam int unsigned BankWidth     = 5;

  localparam logic [2:0] LOAD_COUNT_INIT = 3'd5;

  // Program mode field of the control word (bits 3..2)
  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [18:0] mapped_address;
    logic [1:0]  mirroring;
  } out_item_t;

  // Effective mapping after header resolution
  typedef struct packed {
    logic [BankWidth-1:0] prg_slot0;
    logic [BankWidth-1:0] prg_slot1;
    logic [BankWidth-1:0] chr_slot0;
    logic [BankWidth-1:0] chr_slot1;
    logic [1:0]           mirror;
  } map_view_t;

endpackage

// File: rtl/sbsm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_regs: loader, bank registers and header configuration
// Applies a mapper write and presents the mapping as it stands after the
// item being issued, so reads see current state and writes see new state.
// ----------------------------------------------------------------------------
module sbsm_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbsm_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [sbsm_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                issue_i,
  input  sbsm_pkg::in_item_t                  item_i,
  output sbsm_pkg::map_view_t                 view_o
);
  import sbsm_pkg::*;

  logic [5:0]           prg_count_q;
  logic [4:0]           chr_count_q;
  logic                 hdr_vmirror_q;

  logic [2:0]           load_count_q, load_count_d;
  logic [4:0]           load_shift_q, load_shift_d;
  logic [4:0]           control_q, control_d;
  logic [4:0]           chr_low_q, chr_low_d;
  logic [4:0]           chr_high_q, chr_high_d;
  logic [4:0]           prg_bank_q, prg_bank_d;
  logic [BankWidth-1:0] prg_slot_q [2];
  logic [BankWidth-1:0] prg_slot_d [2];
  logic [BankWidth-1:0] chr_slot_q [2];
  logic [BankWidth-1:0] chr_slot_d [2];
  logic [1:0]           mirror_q, mirror_d;
  logic                 banks_hdr_q, banks_hdr_d;
  logic                 mirror_hdr_q, mirror_hdr_d;

  logic                 do_write;
  logic [2:0]           count_dec;
  logic [4:0]           shift_next;
  logic [BankWidth-1:0] last_prg;
  logic [BankWidth-1:0] last_chr;

  assign do_write   = issue_i && (item_i.action == ACT_MAP_WRITE);
  assign count_dec  = load_count_q - 3'd1;
  assign shift_next = {item_i.data[0], load_shift_q[4:1]};
  assign last_prg   = prg_count_q[4:0] - 5'd1;
  assign last_chr   = (chr_count_q == 5'd0) ? 5'd1 : ({chr_count_q[3:0], 1'b0} - 5'd1);

  always_comb begin
    load_count_d = load_count_q;
    load_shift_d = load_shift_q;
    control_d    = control_q;
    chr_low_d    = chr_low_q;
    chr_high_d   = chr_high_q;
    prg_bank_d   = prg_bank_q;
    prg_slot_d   = prg_slot_q;
    chr_slot_d   = chr_slot_q;
    mirror_d     = mirror_q;
    banks_hdr_d  = banks_hdr_q;
    mirror_hdr_d = mirror_hdr_q;
    if (do_write) begin
      if (item_i.data[7]) begin
        // loader reset; also sets program mode bits 3..2 of the control word
        load_count_d = LOAD_COUNT_INIT;
        load_shift_d = 5'd0;
        control_d    = control_q | 5'b01100;
      end else begin
        load_shift_d = shift_next;
        load_count_d = count_dec;
        if (count_dec == 3'd0) begin
          load_count_d = LOAD_COUNT_INIT;
          case (load_target_e'(item_i.address[14:13]))
            TGT_CONTROL: begin
              control_d    = shift_next;
              mirror_d     = shift_next[1:0];
              mirror_hdr_d = 1'b0;
            end
            TGT_CHR_LOW:  chr_low_d  = shift_next;
            TGT_CHR_HIGH: chr_high_d = shift_next;
            TGT_PROGRAM:  prg_bank_d = shift_next;
            default:      prg_bank_d = shift_next;
          endcase
          // slot recompute from the updated registers
          if (control_d[4]) begin
            chr_slot_d[0] = chr_low_d;
            chr_slot_d[1] = chr_high_d;
          end else begin
            chr_slot_d[0] = chr_low_d & 5'b11110;
            chr_slot_d[1] = chr_low_d | 5'b00001;
          end
          case (control_d[3:2])
            PRG_MODE_FIX_LOW: begin
              prg_slot_d[0] = 5'd0;
              prg_slot_d[1] = prg_bank_d;
            end
            PRG_MODE_FIX_HIGH: begin
              prg_slot_d[0] = prg_bank_d;
              prg_slot_d[1] = last_prg;
            end
            default: begin
              prg_slot_d[0] = prg_bank_d & 5'b11110;
              prg_slot_d[1] = prg_bank_d | 5'b00001;
            end
          endcase
          banks_hdr_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= 6'd2;
      chr_count_q   <= 5'd1;
      hdr_vmirror_q <= 1'b0;
      load_count_q  <= LOAD_COUNT_INIT;
      load_shift_q  <= 5'd0;
      control_q     <= 5'd0;
      chr_low_q     <= 5'd0;
      chr_high_q    <= 5'd0;
      prg_bank_q    <= 5'd0;
      prg_slot_q[0] <= '0;
      prg_slot_q[1] <= '0;
      chr_slot_q[0] <= '0;
      chr_slot_q[1] <= '0;
      mirror_q      <= 2'd0;
      banks_hdr_q   <= 1'b1;
      mirror_hdr_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PRG_BANK_COUNT: prg_count_q   <= cfg_data_i;
          CFG_CHR_BANK_COUNT: chr_count_q   <= cfg_data_i[4:0];
          CFG_HEADER_VMIRROR: hdr_vmirror_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      load_count_q <= load_count_d;
      load_shift_q <= load_shift_d;
      control_q    <= control_d;
      chr_low_q    <= chr_low_d;
      chr_high_q   <= chr_high_d;
      prg_bank_q   <= prg_bank_d;
      prg_slot_q   <= prg_slot_d;
      chr_slot_q   <= chr_slot_d;
      mirror_q     <= mirror_d;
      banks_hdr_q  <= banks_hdr_d;
      mirror_hdr_q <= mirror_hdr_d;
    end
  end

  // Mapping as seen after this item
  always_comb begin
    if (banks_hdr_d) begin
      view_o.prg_slot0 = 5'd0;
      view_o.prg_slot1 = last_prg;
      view_o.chr_slot0 = 5'd0;
      view_o.chr_slot1 = last_chr;
    end else begin
      view_o.prg_slot0 = prg_slot_d[0];
      view_o.prg_slot1 = prg_slot_d[1];
      view_o.chr_slot0 = chr_slot_d[0];
      view_o.chr_slot1 = chr_slot_d[1];
    end
    if (mirror_hdr_d) begin
      view_o.mirror = hdr_vmirror_q ? MIR_VERTICAL : MIR_HORIZONTAL;
    end else begin
      view_o.mirror = mirror_d;
    end
  end

endmodule

// File: rtl/sbsm_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_xlate: address translation
// Forms the program, pattern or nametable offset for one item.
// ----------------------------------------------------------------------------
module sbsm_xlate (
  input  sbsm_pkg::in_item_t   item_i,
  input  sbsm_pkg::map_view_t  view_i,
  output sbsm_pkg::out_item_t  result_o
);
  import sbsm_pkg::*;

  logic [14:0] a;
  logic [4:0]  prg_bank;
  logic [4:0]  chr_bank;

  assign a        = item_i.address;
  assign prg_bank = a[14] ? view_i.prg_slot1 : view_i.prg_slot0;
  assign chr_bank = a[12] ? view_i.chr_slot1 : view_i.chr_slot0;

  always_comb begin
    result_o.mirroring = view_i.mirror;
    case (action_e'(item_i.action))
      ACT_PRG_READ:  result_o.mapped_address = {prg_bank, a[13:0]};
      ACT_MAP_WRITE: result_o.mapped_address = '0;
      ACT_PATTERN:   result_o.mapped_address = {2'b00, chr_bank, a[11:0]};
      ACT_NAMETABLE: begin
        case (mirror_e'(view_i.mirror))
          MIR_SINGLE_LO:  result_o.mapped_address = {9'd0, a[9:0]};
          MIR_SINGLE_HI:  result_o.mapped_address = {8'd0, 1'b1, a[9:0]};
          MIR_VERTICAL:   result_o.mapped_address = {8'd0, a[10:0]};
          MIR_HORIZONTAL: result_o.mapped_address = {8'd0, a[11], a[9:0]};
          default:        result_o.mapped_address = '0;
        endcase
      end
      default:       result_o.mapped_address = '0;
    endcase
  end

endmodule

// File: rtl/serial_bank_switch_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper: serial-load cartridge bank mapper
// Five-write serial loader with control, two pattern bank and program bank
// registers; translates program, pattern and nametable addresses.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | to block  | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//  out      | from block| out_valid_o / out_stall_i | out_item_o (out_item_t)
//  cfg      | to block  | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled. An item sits in the
// input register, is translated and applied to the mapper state, and lands
// in the output register. Reset is asynchronous, active low, and gives the
// header mapping at once. A stall on the output holds the output register,
// and the input register as well once it holds an item; in_stall_o rises
// only while the input register holds an item behind a stalled one.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sbsm_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sbsm_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [sbsm_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [sbsm_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import sbsm_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      out_free;   // output register can take a new result
  logic      issue;      // input register item moves to the output
  map_view_t view;
  out_item_t result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Mapper state; loader and bank registers change only when an item issues, the header configuration on cfg_we_i
  sbsm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .issue_i     (issue),
    .item_i      (in_item_q),
    .view_o      (view)
  );

  sbsm_xlate u_xlate (
    .item_i   (in_item_q),
    .view_i   (view),
    .result_o (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/sbsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_checker: port-level checks for the mapper
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module sbsm_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  sbsm_pkg::out_item_t  out_item_o
);
  import sbsm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // input side never stalls with an empty output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // an accepted item reaches the output when not blocked
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i |=> out_valid_o)
    else $error("item did not reach output");

  // a held item behind a stalled result stalls the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && $past(in_acc) |-> in_stall_o)
    else $error("input accepted with full pipeline");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
